// ===== hw/rtl/swpf_pkg.sv =====
// Shared constants, types and lane control records for the window fit predictor.
package swpf_pkg;

    localparam int DEPTH     = 64;                 // history entries per axis
    localparam int AW        = $clog2(DEPTH);      // history address width
    localparam int NW        = AW + 1;             // window length width (holds DEPTH)
    localparam int MAX_PRED  = 16;                 // results per request at most
    localparam int PCW       = $clog2(MAX_PRED);   // result counter width
    localparam int CW        = 40;                 // coefficient width, Q.16 sample units
    localparam int SYW       = 23;                 // sum of y
    localparam int SUYW      = 28;                 // sum of u*y
    localparam int SU2W      = 34;                 // sum of u^2*y
    localparam int S2W       = 17;                 // sum of u^2
    localparam int S4W       = 28;                 // sum of u^4
    localparam int U2W       = 14;                 // u^2 for window and prediction times
    localparam int NUMW      = 52;                 // quadratic numerators
    localparam int RESW      = 26;                 // residual, Q.4
    localparam int SSEW      = 56;                 // squared error sum per axis
    localparam int NMW       = 58;                 // divider numerator, signed
    localparam int DNW       = 68;                 // divider dividend magnitude
    localparam int DDW       = 36;                 // divider divisor
    localparam int QW        = DNW + 2;            // rounded signed quotient
    localparam int FRAC      = 16;                 // extra coefficient fraction bits

    typedef enum logic [2:0] {
        CFG_FIT_STEPS     = 3'd0,
        CFG_FIT_MODE      = 3'd1,
        CFG_PREDICT_COUNT = 3'd2,
        CFG_OFFSET_X      = 3'd3,
        CFG_OFFSET_Y      = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        LOP_IDLE,
        LOP_CLR,    // clear sums, zero the square term
        LOP_HOLD,   // hold the newest point as the fit
        LOP_MUL,    // window products
        LOP_ACC,    // window sums
        LOP_NUM,    // quadratic numerators
        LOP_EMUL,   // fit products at a window time
        LOP_EDIF,   // rounded residual
        LOP_EACC,   // squared error sum
        LOP_PMUL,   // fit products at a prediction time
        LOP_PRED    // rounded, saturated prediction
    } t_lane_op;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_C0,
        LD_C1,
        LD_C2
    } t_coef;

    typedef struct packed {
        logic                   wr_en;
        logic [AW-1:0]          wr_addr;
        logic [AW-1:0]          rd_addr;
        t_lane_op               op;
        logic signed [7:0]      u;
        logic [U2W-1:0]         u2;
        logic [NW-1:0]          n;
        logic [S2W-1:0]         s2;
        logic [S4W-1:0]         s4;
        t_coef                  ld;
        logic signed [CW-1:0]   quot;
    } t_lane_ctl;

    typedef struct packed {
        logic signed [SYW-1:0]  sy;
        logic signed [SUYW-1:0] suy;
        logic signed [NUMW-1:0] nc0;
        logic signed [NUMW-1:0] nc2;
        logic [SSEW-1:0]        sse;
        logic signed [15:0]     pred;
        logic signed [15:0]     vel;
    } t_lane_res;

endpackage

// ===== hw/rtl/swpf_div.sv =====
// Shared radix-2 restoring divider with round half away from zero.
module swpf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_neg,
    input  logic [swpf_pkg::DNW-1:0]      i_num,
    input  logic [swpf_pkg::DDW-1:0]      i_den,
    output logic                          o_done,
    output logic signed [swpf_pkg::QW-1:0] o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [6:0]                    r_cnt;
    logic [swpf_pkg::DNW-1:0]      r_q;
    logic [swpf_pkg::DDW-1:0]      r_rem;
    logic [swpf_pkg::DDW-1:0]      r_den;
    logic                          r_neg;
    logic signed [swpf_pkg::QW-1:0] r_quot;

    logic [swpf_pkg::DDW:0]        rem_sh;
    logic                          ge;
    logic [swpf_pkg::DDW:0]        rem_sub;
    logic                          rnd;
    logic [swpf_pkg::DNW:0]        mag;

    assign rem_sh  = {r_rem, r_q[swpf_pkg::DNW-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign rnd     = {r_rem, 1'b0} >= {1'b0, r_den};
    assign mag     = {1'b0, r_q} + {{swpf_pkg::DNW{1'b0}}, rnd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(swpf_pkg::DNW);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 7'd1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_q   <= {r_q[swpf_pkg::DNW-2:0], ge};
                r_rem <= ge ? rem_sub[swpf_pkg::DDW-1:0] : rem_sh[swpf_pkg::DDW-1:0];
            end else if (r_den == '0) begin
                r_quot <= '0;
            end else if (r_neg) begin
                r_quot <= -$signed({1'b0, mag});
            end else begin
                r_quot <= $signed({1'b0, mag});
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/swpf_lane.sv =====
// One axis lane: history memory, window sums, fit coefficients, residuals and predictions.
module swpf_lane (
    input  logic                  i_clk,
    input  swpf_pkg::t_lane_ctl   i_ctl,
    input  logic signed [15:0]    i_sample,
    input  logic signed [15:0]    i_offset,
    output swpf_pkg::t_lane_res   o_res
);

    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input int unsigned sh);
        logic [63:0] m;
        logic [63:0] q;
        m = v[63] ? 64'(-v) : 64'(v);
        q = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    logic signed [15:0]                r_mem [swpf_pkg::DEPTH];
    logic signed [15:0]                r_rd;
    logic signed [15:0]                r_yd;
    logic signed [23:0]                r_p1;
    logic signed [30:0]                r_p2;
    logic signed [swpf_pkg::SYW-1:0]   r_sy;
    logic signed [swpf_pkg::SUYW-1:0]  r_suy;
    logic signed [swpf_pkg::SU2W-1:0]  r_su2y;
    logic signed [swpf_pkg::NUMW-1:0]  r_nc0;
    logic signed [swpf_pkg::NUMW-1:0]  r_nc2;
    logic signed [swpf_pkg::CW-1:0]    r_c0;
    logic signed [swpf_pkg::CW-1:0]    r_c1;
    logic signed [swpf_pkg::CW-1:0]    r_c2;
    logic signed [swpf_pkg::CW+7:0]    r_m1;
    logic signed [swpf_pkg::CW+14:0]   r_m2;
    logic signed [swpf_pkg::RESW-1:0]  r_res;
    logic [swpf_pkg::SSEW-1:0]         r_sse;
    logic signed [15:0]                r_pred;

    logic signed [swpf_pkg::U2W:0]     u2s;
    logic signed [23:0]                uy;
    logic signed [30:0]                u2y;
    logic signed [swpf_pkg::NUMW-1:0]  pa;
    logic signed [swpf_pkg::NUMW-1:0]  pb;
    logic signed [swpf_pkg::NUMW-1:0]  pc;
    logic signed [swpf_pkg::NUMW-1:0]  pd;
    logic signed [swpf_pkg::CW+7:0]    m1;
    logic signed [swpf_pkg::CW+14:0]   m2;
    logic signed [63:0]                ev;
    logic signed [63:0]                dif;
    logic signed [63:0]                pv;
    logic signed [2*swpf_pkg::RESW-1:0] sq;

    assign u2s = $signed({1'b0, i_ctl.u2});
    assign uy  = i_ctl.u * r_rd;
    assign u2y = u2s * r_rd;
    assign pa  = $signed({1'b0, i_ctl.s4}) * r_sy;
    assign pb  = $signed({1'b0, i_ctl.s2}) * r_su2y;
    assign pc  = $signed({1'b0, i_ctl.n}) * r_su2y;
    assign pd  = $signed({1'b0, i_ctl.s2}) * r_sy;
    assign m1  = r_c1 * i_ctl.u;
    assign m2  = r_c2 * u2s;
    assign ev  = 64'(r_c0) + 64'(r_m1) + 64'(r_m2);
    assign dif = (64'(r_yd) <<< swpf_pkg::FRAC) - ev;
    assign pv  = ev + (64'(i_offset) <<< swpf_pkg::FRAC);
    assign sq  = r_res * r_res;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_sample;
        end
        r_rd <= r_mem[i_ctl.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            swpf_pkg::LOP_CLR: begin
                r_sy   <= '0;
                r_suy  <= '0;
                r_su2y <= '0;
                r_sse  <= '0;
                r_c2   <= '0;
            end
            swpf_pkg::LOP_HOLD: begin
                r_c0 <= swpf_pkg::CW'(i_sample) <<< swpf_pkg::FRAC;
                r_c1 <= '0;
                r_c2 <= '0;
            end
            swpf_pkg::LOP_MUL: begin
                r_yd <= r_rd;
                r_p1 <= uy;
                r_p2 <= u2y;
            end
            swpf_pkg::LOP_ACC: begin
                r_sy   <= r_sy + swpf_pkg::SYW'(r_yd);
                r_suy  <= r_suy + swpf_pkg::SUYW'(r_p1);
                r_su2y <= r_su2y + swpf_pkg::SU2W'(r_p2);
            end
            swpf_pkg::LOP_NUM: begin
                r_nc0 <= pa - pb;
                r_nc2 <= pc - pd;
            end
            swpf_pkg::LOP_EMUL: begin
                r_yd <= r_rd;
                r_m1 <= m1;
                r_m2 <= m2;
            end
            swpf_pkg::LOP_EDIF: begin
                r_res <= swpf_pkg::RESW'(rnd_shr(dif, 12));
            end
            swpf_pkg::LOP_EACC: begin
                r_sse <= r_sse + swpf_pkg::SSEW'($unsigned(sq));
            end
            swpf_pkg::LOP_PMUL: begin
                r_m1 <= m1;
                r_m2 <= m2;
            end
            swpf_pkg::LOP_PRED: begin
                r_pred <= sat16(rnd_shr(pv, swpf_pkg::FRAC));
            end
            default: begin
            end
        endcase
        case (i_ctl.ld)
            swpf_pkg::LD_C0: r_c0 <= i_ctl.quot;
            swpf_pkg::LD_C1: r_c1 <= i_ctl.quot;
            swpf_pkg::LD_C2: r_c2 <= i_ctl.quot;
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.sy   = r_sy;
        o_res.suy  = r_suy;
        o_res.nc0  = r_nc0;
        o_res.nc2  = r_nc2;
        o_res.sse  = r_sse;
        o_res.pred = r_pred;
        // slope per step is twice the coefficient of the centred time
        o_res.vel  = sat16(rnd_shr(64'(r_c1), swpf_pkg::FRAC - 1));
    end

endmodule

// ===== hw/rtl/sliding_window_poly_fit_predictor_top.sv =====
// Top level: request intake, window sequencer, shared divider and result merge.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------------
//  in       | in        | i_in_valid/o_in_stall | i_sample_x, i_sample_y, i_restart
//  out      | out       | o_out_valid/i_out_stall | o_pred_x/y, o_velocity_x/y, o_fit_status,
//           |           |                       | o_fit_error, o_last
//  cfg      | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request at a time. A fitted request runs its coefficient divisions (two per axis
// when linear, three when quadratic) and one error division through the divider,
// shared by all of them, which works through its 68-bit dividend and sets most of the time.
// A held request (quadratic below three points) skips the fit and goes straight to the results.
// Reset clears control and configuration; history needs no clearing.
// o_in_stall is high whenever a request is in work; a stalled result holds.
module sliding_window_poly_fit_predictor_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [15:0]  i_sample_x,
    input  logic [15:0]  i_sample_y,
    input  logic         i_restart,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [15:0]  o_pred_x,
    output logic [15:0]  o_pred_y,
    output logic [15:0]  o_velocity_x,
    output logic [15:0]  o_velocity_y,
    output logic         o_fit_status,
    output logic [31:0]  o_fit_error,
    output logic         o_last,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_SUM   = 10'b00_0000_0010,
        S_NUM   = 10'b00_0000_0100,
        S_DIV   = 10'b00_0000_1000,
        S_DWAIT = 10'b00_0001_0000,
        S_ERR   = 10'b00_0010_0000,
        S_PRED  = 10'b00_0100_0000,
        S_OUT   = 10'b00_1000_0000,
        S_SPARE = 10'b01_0000_0000,
        S_SPAR2 = 10'b10_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        J_C1,
        J_C0,
        J_C2,
        J_MSE
    } t_job;

    // configuration
    logic [swpf_pkg::NW-1:0]       r_fit_steps;
    logic                          r_fit_mode;
    logic [4:0]                    r_pred_cnt;
    logic signed [15:0]            r_off_x;
    logic signed [15:0]            r_off_y;

    // control
    t_state                        r_state;
    t_job                          r_job;
    logic                          r_ax;
    logic [1:0]                    r_ph;
    logic [swpf_pkg::AW-1:0]       r_k;
    logic [swpf_pkg::PCW-1:0]      r_i;
    logic [swpf_pkg::NW-1:0]       r_fill;
    logic [swpf_pkg::AW-1:0]       r_wp;
    logic [swpf_pkg::NW-1:0]       r_n;
    logic [swpf_pkg::PCW:0]        r_cnt;
    logic                          r_quad;
    logic                          r_held;
    logic                          r_ov;

    // datapath
    logic [swpf_pkg::AW-1:0]       r_base;
    logic signed [7:0]             r_u;
    logic [swpf_pkg::U2W-1:0]      r_u2;
    logic [swpf_pkg::S4W-1:0]      r_u4;
    logic [swpf_pkg::S2W-1:0]      r_s2;
    logic [swpf_pkg::S4W-1:0]      r_s4;
    logic [swpf_pkg::DDW-1:0]      r_det;
    logic [31:0]                   r_err;

    logic                          accept;
    logic [swpf_pkg::NW-1:0]       fill_base;
    logic [swpf_pkg::AW-1:0]       wp_base;
    logic [swpf_pkg::NW-1:0]       fill_new;
    logic [swpf_pkg::AW-1:0]       wp_new;
    logic [swpf_pkg::NW-1:0]       fs;
    logic [swpf_pkg::NW-1:0]       n_new;
    logic [swpf_pkg::PCW:0]        cnt_new;
    logic                          held_new;
    logic signed [7:0]             u_sw;
    logic signed [7:0]             u_pr;
    logic signed [7:0]             u_nx;
    logic signed [15:0]            u_sq;
    logic [swpf_pkg::NW+swpf_pkg::S4W-1:0] ns4;
    logic [2*swpf_pkg::S2W-1:0]    s2s2;
    logic                          k_end;
    logic                          i_end;

    swpf_pkg::t_lane_ctl           ctl;
    swpf_pkg::t_lane_ctl           ctl_x;
    swpf_pkg::t_lane_ctl           ctl_y;
    swpf_pkg::t_lane_res           res_x;
    swpf_pkg::t_lane_res           res_y;
    swpf_pkg::t_lane_res           res_s;

    logic                          div_start;
    logic                          div_done;
    logic signed [swpf_pkg::NMW-1:0] div_snum;
    logic [swpf_pkg::NMW-1:0]      div_mag;
    logic                          div_sh;
    logic [swpf_pkg::DNW-1:0]      div_num;
    logic [swpf_pkg::DDW-1:0]      div_den;
    logic signed [swpf_pkg::QW-1:0] div_quot;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        fill_base = i_restart ? '0 : r_fill;
        wp_base   = i_restart ? '0 : r_wp;
        fill_new  = (fill_base == swpf_pkg::NW'(swpf_pkg::DEPTH)) ? fill_base
                                                                  : fill_base + 1'b1;
        wp_new    = wp_base + 1'b1;
        if (r_fit_steps == '0) begin
            fs = swpf_pkg::NW'(1);
        end else if (r_fit_steps > swpf_pkg::NW'(swpf_pkg::DEPTH)) begin
            fs = swpf_pkg::NW'(swpf_pkg::DEPTH);
        end else begin
            fs = r_fit_steps;
        end
        n_new = (fs < fill_new) ? fs : fill_new;
        if (r_pred_cnt == '0) begin
            cnt_new = (swpf_pkg::PCW+1)'(1);
        end else if (r_pred_cnt > 5'(swpf_pkg::MAX_PRED)) begin
            cnt_new = (swpf_pkg::PCW+1)'(swpf_pkg::MAX_PRED);
        end else begin
            cnt_new = (swpf_pkg::PCW+1)'(r_pred_cnt);
        end
        held_new = r_fit_mode && (n_new < swpf_pkg::NW'(3));
    end

    // centred time: window t = 0..n-1 maps to u = 2t-(n-1); predictions continue past it
    always_comb begin
        u_sw = $signed({1'b0, r_k, 1'b0}) - $signed(8'(r_n)) + 8'sd1;
        u_pr = $signed(8'(r_n)) + $signed(8'({r_i, 1'b0})) + 8'sd1;
        u_nx = (r_state == S_PRED) ? u_pr : u_sw;
        u_sq = u_nx * u_nx;
    end

    assign ns4   = r_n * r_s4;
    assign s2s2  = r_s2 * r_s2;
    assign k_end = r_k == swpf_pkg::AW'(r_n - 1'b1);
    assign i_end = r_i == swpf_pkg::PCW'(r_cnt - 1'b1);

    assign res_s = r_ax ? res_y : res_x;

    // divider request for the current job
    always_comb begin
        div_sh   = 1'b1;
        div_snum = '0;
        div_den  = '0;
        case (r_job)
            J_C1: begin
                div_snum = swpf_pkg::NMW'(res_s.suy);
                div_den  = swpf_pkg::DDW'(r_s2);
            end
            J_C0: begin
                div_snum = r_quad ? swpf_pkg::NMW'(res_s.nc0) : swpf_pkg::NMW'(res_s.sy);
                div_den  = r_quad ? r_det : swpf_pkg::DDW'(r_n);
            end
            J_C2: begin
                div_snum = swpf_pkg::NMW'(res_s.nc2);
                div_den  = r_det;
            end
            default: begin
                div_sh   = 1'b0;
                div_snum = $signed(swpf_pkg::NMW'({1'b0, res_x.sse} + {1'b0, res_y.sse}));
                div_den  = r_quad ? swpf_pkg::DDW'({r_n, 8'b0})
                                  : swpf_pkg::DDW'({r_n, 9'b0});
            end
        endcase
        div_mag = div_snum[swpf_pkg::NMW-1] ? $unsigned(-div_snum) : $unsigned(div_snum);
        div_num = div_sh ? {div_mag[swpf_pkg::DNW-swpf_pkg::FRAC-1:0], {swpf_pkg::FRAC{1'b0}}}
                         : swpf_pkg::DNW'(div_mag);
    end

    assign div_start = r_state == S_DIV;

    swpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_neg   (div_snum[swpf_pkg::NMW-1]),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // lane control
    always_comb begin
        ctl.wr_en   = accept;
        ctl.wr_addr = wp_base;
        ctl.rd_addr = r_base + r_k;
        ctl.op      = swpf_pkg::LOP_IDLE;
        ctl.u       = r_u;
        ctl.u2      = r_u2;
        ctl.n       = r_n;
        ctl.s2      = r_s2;
        ctl.s4      = r_s4;
        ctl.ld      = swpf_pkg::LD_NONE;
        ctl.quot    = div_quot[swpf_pkg::CW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    ctl.op = held_new ? swpf_pkg::LOP_HOLD : swpf_pkg::LOP_CLR;
                end
            end
            S_SUM: begin
                if (r_ph == 2'd1) begin
                    ctl.op = swpf_pkg::LOP_MUL;
                end else if (r_ph == 2'd2) begin
                    ctl.op = swpf_pkg::LOP_ACC;
                end
            end
            S_NUM: ctl.op = swpf_pkg::LOP_NUM;
            S_DWAIT: begin
                if (div_done) begin
                    case (r_job)
                        J_C0:    ctl.ld = swpf_pkg::LD_C0;
                        J_C1:    ctl.ld = swpf_pkg::LD_C1;
                        J_C2:    ctl.ld = swpf_pkg::LD_C2;
                        default: ctl.ld = swpf_pkg::LD_NONE;
                    endcase
                end
            end
            S_ERR: begin
                case (r_ph)
                    2'd1:    ctl.op = swpf_pkg::LOP_EMUL;
                    2'd2:    ctl.op = swpf_pkg::LOP_EDIF;
                    2'd3:    ctl.op = swpf_pkg::LOP_EACC;
                    default: ctl.op = swpf_pkg::LOP_IDLE;
                endcase
            end
            S_PRED: begin
                if (r_ph == 2'd1) begin
                    ctl.op = swpf_pkg::LOP_PMUL;
                end else if (r_ph == 2'd2) begin
                    ctl.op = swpf_pkg::LOP_PRED;
                end
            end
            default: ctl.op = swpf_pkg::LOP_IDLE;
        endcase
        ctl_x    = ctl;
        ctl_y    = ctl;
        ctl_x.ld = r_ax ? swpf_pkg::LD_NONE : ctl.ld;
        ctl_y.ld = r_ax ? ctl.ld : swpf_pkg::LD_NONE;
    end

    swpf_lane u_lane_x (
        .i_clk    (i_clk),
        .i_ctl    (ctl_x),
        .i_sample (i_sample_x),
        .i_offset (r_off_x),
        .o_res    (res_x)
    );

    swpf_lane u_lane_y (
        .i_clk    (i_clk),
        .i_ctl    (ctl_y),
        .i_sample (i_sample_y),
        .i_offset (r_off_y),
        .o_res    (res_y)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_steps <= swpf_pkg::NW'(10);
            r_fit_mode  <= 1'b0;
            r_pred_cnt  <= 5'd1;
            r_off_x     <= '0;
            r_off_y     <= '0;
        end else if (i_cfg_valid) begin
            unique case (swpf_pkg::t_cfg_idx'(i_cfg_index))
                swpf_pkg::CFG_FIT_STEPS:     r_fit_steps <= i_cfg_data[swpf_pkg::NW-1:0];
                swpf_pkg::CFG_FIT_MODE:      r_fit_mode  <= i_cfg_data[0];
                swpf_pkg::CFG_PREDICT_COUNT: r_pred_cnt  <= i_cfg_data[4:0];
                swpf_pkg::CFG_OFFSET_X:      r_off_x     <= i_cfg_data;
                swpf_pkg::CFG_OFFSET_Y:      r_off_y     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= J_C1;
            r_ax    <= 1'b0;
            r_ph    <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_fill  <= '0;
            r_wp    <= '0;
            r_n     <= '0;
            r_cnt   <= '0;
            r_quad  <= 1'b0;
            r_held  <= 1'b0;
            r_ov    <= 1'b0;
            r_err   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_fill <= fill_new;
                        r_wp   <= wp_new;
                        r_n    <= n_new;
                        r_cnt  <= cnt_new;
                        r_quad <= r_fit_mode;
                        r_held <= held_new;
                        r_base <= wp_new - swpf_pkg::AW'(n_new);
                        r_k    <= '0;
                        r_i    <= '0;
                        r_ph   <= '0;
                        r_s2   <= '0;
                        r_s4   <= '0;
                        r_err  <= '0;
                        r_state <= held_new ? S_PRED : S_SUM;
                    end
                end
                S_SUM: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd0) begin
                        r_u  <= u_nx;
                        r_u2 <= swpf_pkg::U2W'(u_sq);
                    end else if (r_ph == 2'd1) begin
                        r_u4 <= swpf_pkg::S4W'(r_u2 * r_u2);
                    end else begin
                        r_ph <= '0;
                        r_s2 <= r_s2 + swpf_pkg::S2W'(r_u2);
                        r_s4 <= r_s4 + r_u4;
                        r_k  <= r_k + 1'b1;
                        if (k_end) begin
                            r_k     <= '0;
                            r_state <= S_NUM;
                        end
                    end
                end
                S_NUM: begin
                    r_det   <= swpf_pkg::DDW'(ns4) - swpf_pkg::DDW'(s2s2);
                    r_job   <= J_C1;
                    r_ax    <= 1'b0;
                    r_state <= S_DIV;
                end
                S_DIV: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done) begin
                        r_ax    <= ~r_ax;
                        r_state <= S_DIV;
                        case (r_job)
                            J_C1: begin
                                if (r_ax) begin
                                    r_job <= J_C0;
                                end
                            end
                            J_C0: begin
                                if (r_ax) begin
                                    if (r_quad) begin
                                        r_job <= J_C2;
                                    end else begin
                                        r_ph    <= '0;
                                        r_state <= S_ERR;
                                    end
                                end
                            end
                            J_C2: begin
                                if (r_ax) begin
                                    r_ph    <= '0;
                                    r_state <= S_ERR;
                                end
                            end
                            default: begin
                                // error quotient is never negative; clip to 32 bits
                                r_ax    <= 1'b0;
                                r_err   <= (div_quot[swpf_pkg::QW-1:32] != '0) ? 32'hffff_ffff
                                                                               : div_quot[31:0];
                                r_i     <= '0;
                                r_ph    <= '0;
                                r_state <= S_PRED;
                            end
                        endcase
                    end
                end
                S_ERR: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd0) begin
                        r_u  <= u_nx;
                        r_u2 <= swpf_pkg::U2W'(u_sq);
                    end else if (r_ph == 2'd3) begin
                        r_k <= r_k + 1'b1;
                        if (k_end) begin
                            r_k     <= '0;
                            r_job   <= J_MSE;
                            r_ax    <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_PRED: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd0) begin
                        r_u  <= u_nx;
                        r_u2 <= swpf_pkg::U2W'(u_sq);
                    end else if (r_ph == 2'd2) begin
                        r_ph    <= '0;
                        r_ov    <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold the result until the sink takes it
                    if (!i_out_stall) begin
                        r_ov <= 1'b0;
                        if (i_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_PRED;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = r_state != S_IDLE;
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_ov;
    assign o_pred_x     = res_x.pred;
    assign o_pred_y     = res_y.pred;
    assign o_velocity_x = res_x.vel;
    assign o_velocity_y = res_y.vel;
    assign o_fit_status = r_held;
    assign o_fit_error  = r_err;
    assign o_last       = i_end;

endmodule

// ===== verif/tb_sliding_window_poly_fit_predictor_top.sv =====
// Self-checking testbench for the sliding-window polynomial fit predictor.
module tb_sliding_window_poly_fit_predictor_top;
    import swpf_pkg::*;

    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [15:0] pred_x;
        logic [15:0] pred_y;
        logic [15:0] vel_x;
        logic [15:0] vel_y;
        logic        status;
        logic [31:0] err;
        logic        last;
    } t_prediction;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        restart;
    } t_sample_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [15:0] i_sample_x;
    logic [15:0] i_sample_y;
    logic        i_restart;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_pred_x;
    logic [15:0] o_pred_y;
    logic [15:0] o_velocity_x;
    logic [15:0] o_velocity_y;
    logic        o_fit_status;
    logic [31:0] o_fit_error;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    sliding_window_poly_fit_predictor_top i_dut (.*);

    // shadow of the block's state and registers
    logic signed [15:0] hist_x [DEPTH];
    logic signed [15:0] hist_y [DEPTH];
    int unsigned        fill_cnt;
    int unsigned        wr_ptr;
    int unsigned        steps_reg;
    bit                 quad_reg;
    int unsigned        count_reg;
    logic signed [15:0] off_x_reg;
    logic signed [15:0] off_y_reg;

    t_prediction pending_predictions [$];
    t_prediction got;
    t_prediction want;
    int          mismatches;
    int          requests_sent;
    int          results_seen;
    int          hold_reqs;
    int          hold_seen;
    int          hold_left;
    int          stall_mode;
    int          stall_tick;
    int          burst_left;

    t_sample_row directed_rows [12] = '{
        '{16'sd100,   -16'sd100,  1'b1},
        '{16'h7fff,   16'h7fff,   1'b0},
        '{16'h8000,   16'h8000,   1'b0},
        '{16'h0000,   16'hffff,   1'b0},
        '{16'hffff,   16'h0000,   1'b0},
        '{16'h8000,   16'h7fff,   1'b1},
        '{16'h7fff,   16'h8000,   1'b0},
        '{16'sd16,    16'sd32,    1'b0},
        '{16'sd32,    16'sd64,    1'b0},
        '{16'sd48,    16'sd96,    1'b0},
        '{16'h0000,   16'h0000,   1'b1},
        '{16'h5555,   16'haaaa,   1'b0}
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #20_000_000;
        $display("[sliding_window_poly_fit_predictor_top] ERROR");
        $finish;
    end

    // round(num * 2^sh / den), half away from zero
    function automatic longint round_div(longint num, longint unsigned den, int sh);
        longint unsigned m, q, r, f, q2, r2, res;
        bit neg;
        if (den == 0)
            return 0;
        neg = num < 0;
        m = neg ? -num : num;
        q = m / den;
        r = m % den;
        f = r << sh;
        q2 = f / den;
        r2 = f % den;
        res = (q << sh) + q2 + ((r2 >= den - r2) ? 64'd1 : 64'd0);
        return neg ? -longint'(res) : longint'(res);
    endfunction

    function automatic logic [15:0] sat16(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic void fit_axis(input longint w[DEPTH], input int n, input bit quad,
                                     output longint c0, output longint c1,
                                     output longint c2, output longint unsigned sse);
        longint sy, suy, su2y, s2, s4, u, det, r;
        sy = 0; suy = 0; su2y = 0; s2 = 0; s4 = 0;
        for (int k = 0; k < n; k++) begin
            u = 2 * k - (n - 1);
            sy += w[k];
            suy += u * w[k];
            su2y += u * u * w[k];
            s2 += u * u;
            s4 += u * u * u * u;
        end
        c1 = round_div(suy, s2, FRAC);
        if (quad) begin
            det = n * s4 - s2 * s2;
            c0 = round_div(s4 * sy - s2 * su2y, det, FRAC);
            c2 = round_div(n * su2y - s2 * sy, det, FRAC);
        end else begin
            c0 = round_div(sy, n, FRAC);
            c2 = 0;
        end
        sse = 0;
        for (int k = 0; k < n; k++) begin
            u = 2 * k - (n - 1);
            r = round_div(w[k] * 65536 - (c0 + c1 * u + c2 * u * u), 4096, 0);
            sse += r * r;
        end
    endfunction

    // store one sample, fit the window and queue the extrapolated points
    function automatic void fit_and_extrapolate(logic signed [15:0] sx, logic signed [15:0] sy,
                                                bit restart, bit typed);
        longint wx [DEPTH];
        longint wy [DEPTH];
        longint ax0, ax1, ax2, ay0, ay1, ay2, u, q;
        longint unsigned ex, ey;
        int n, cnt;
        bit held;
        t_prediction p;
        if (restart) begin
            fill_cnt = 0;
            wr_ptr = 0;
        end
        hist_x[wr_ptr] = sx;
        hist_y[wr_ptr] = sy;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        if (fill_cnt < DEPTH)
            fill_cnt++;
        n = (steps_reg < 1) ? 1 : (steps_reg > DEPTH) ? DEPTH : steps_reg;
        if (n > fill_cnt)
            n = fill_cnt;
        cnt = (count_reg < 1) ? 1 : (count_reg > MAX_PRED) ? MAX_PRED : count_reg;
        held = quad_reg && n < 3;
        p.vel_x = '0;
        p.vel_y = '0;
        p.err = '0;
        if (!held) begin
            for (int k = 0; k < n; k++) begin
                wx[k] = hist_x[(wr_ptr + DEPTH - n + k) % DEPTH];
                wy[k] = hist_y[(wr_ptr + DEPTH - n + k) % DEPTH];
            end
            fit_axis(wx, n, quad_reg, ax0, ax1, ax2, ex);
            fit_axis(wy, n, quad_reg, ay0, ay1, ay2, ey);
            p.vel_x = sat16(round_div(2 * ax1, 65536, 0));
            p.vel_y = sat16(round_div(2 * ay1, 65536, 0));
            q = round_div(longint'(ex + ey), n * (quad_reg ? 256 : 512), 0);
            p.err = (q > 64'hffff_ffff) ? 32'hffff_ffff : q[31:0];
        end
        for (int i = 0; i < cnt; i++) begin
            if (held) begin
                p.pred_x = sat16(longint'(sx) + off_x_reg);
                p.pred_y = sat16(longint'(sy) + off_y_reg);
            end else begin
                u = n + 1 + 2 * i;
                p.pred_x = sat16(round_div(ax0 + ax1 * u + ax2 * u * u
                                           + longint'(off_x_reg) * 65536, 65536, 0));
                p.pred_y = sat16(round_div(ay0 + ay1 * u + ay2 * u * u
                                           + longint'(off_y_reg) * 65536, 65536, 0));
            end
            p.status = held;
            p.last = (i + 1 == cnt);
            // a fresh history holds one point: repeat it with no slope and no error
            if (typed) begin
                p.pred_x = sx;
                p.pred_y = sy;
                p.vel_x = '0;
                p.vel_y = '0;
                p.err = '0;
                p.status = quad_reg;
            end
            pending_predictions.push_back(p);
        end
    endfunction

    // receiver: random stall pattern drawn from three modes, with a long hold on request
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 0)
            stall_mode <= $urandom_range(0, 2);
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            got = '{o_pred_x, o_pred_y, o_velocity_x, o_velocity_y,
                    o_fit_status, o_fit_error, o_last};
            if (pending_predictions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pred %h %h", o_pred_x, o_pred_y);
            end else begin
                want = pending_predictions.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp pred %h %h vel %h %h st %b err %h last %b",
                                 want.pred_x, want.pred_y, want.vel_x, want.vel_y,
                                 want.status, want.err, want.last,
                                 "\n          got pred %h %h vel %h %h st %b err %h last %b",
                                 got.pred_x, got.pred_y, got.vel_x, got.vel_y,
                                 got.status, got.err, got.last);
                end
            end
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FIT_STEPS:     steps_reg = data[6:0];
            CFG_FIT_MODE:      quad_reg = data[0];
            CFG_PREDICT_COUNT: count_reg = data[4:0];
            CFG_OFFSET_X:      off_x_reg = data;
            default:           off_y_reg = data;
        endcase
    endtask

    task automatic set_config(logic [15:0] steps, logic [15:0] mode, logic [15:0] cnt,
                              logic [15:0] ox, logic [15:0] oy);
        cfg_write(CFG_FIT_STEPS, steps);
        cfg_write(CFG_FIT_MODE, mode);
        cfg_write(CFG_PREDICT_COUNT, cnt);
        cfg_write(CFG_OFFSET_X, ox);
        cfg_write(CFG_OFFSET_Y, oy);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_predictions.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // offer one request, idling between bursts; valid stays high inside a burst
    task automatic send_sample(logic [15:0] x, logic [15:0] y, bit restart, bit typed);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_sample_x <= x;
        i_sample_y <= y;
        i_restart <= restart;
        do @(posedge i_clk); while (o_in_stall);
        fit_and_extrapolate(x, y, restart, typed);
        requests_sent++;
    endtask

    task automatic run_trajectory(int items, bit pause_midway);
        int px, py, vx, vy, spread;
        px = $urandom_range(0, 65535) - 32768;
        py = $urandom_range(0, 65535) - 32768;
        vx = $urandom_range(0, 400) - 200;
        vy = $urandom_range(0, 400) - 200;
        spread = 1 << $urandom_range(0, 8);
        for (int i = 0; i < items; i++) begin
            if (pause_midway && i == items / 2) begin
                i_in_valid <= 1'b0;
                burst_left = 0;
                wait_drained();
            end
            if ($urandom_range(0, 9) == 0) begin
                // noise: full-range point, sometimes with a restart
                send_sample($urandom, $urandom, $urandom_range(0, 3) == 0, 1'b0);
            end else begin
                px += vx + $urandom_range(0, spread) - spread / 2;
                py += vy + $urandom_range(0, spread) - spread / 2;
                vx += $urandom_range(0, 8) - 4;
                vy += $urandom_range(0, 8) - 4;
                send_sample(px[15:0], py[15:0], $urandom_range(0, 19) == 0, 1'b0);
            end
        end
        i_in_valid <= 1'b0;
        burst_left = 0;
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_sample_x = '0;
        i_sample_y = '0;
        i_restart = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FIT_STEPS;
        i_cfg_data = '0;
        fill_cnt = 0;
        wr_ptr = 0;
        steps_reg = 10;
        quad_reg = 1'b0;
        count_reg = 1;
        off_x_reg = '0;
        off_y_reg = '0;
        mismatches = 0;
        requests_sent = 0;
        results_seen = 0;
        hold_reqs = 0;
        hold_seen = 0;
        hold_left = 0;
        stall_mode = 0;
        stall_tick = 0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings (linear), then quadratic with three results each
        foreach (directed_rows[r])
            send_sample(directed_rows[r].x, directed_rows[r].y,
                        directed_rows[r].restart, directed_rows[r].restart);
        i_in_valid <= 1'b0;
        burst_left = 0;
        wait_drained();
        set_config(16'd10, 16'd1, 16'd3, 16'd0, 16'd0);
        foreach (directed_rows[r])
            send_sample(directed_rows[r].x, directed_rows[r].y,
                        directed_rows[r].restart, directed_rows[r].restart);
        i_in_valid <= 1'b0;
        burst_left = 0;
        wait_drained();

        // extremes of the registers, out-of-range values included
        set_config(16'd0, 16'd0, 16'd0, 16'h8000, 16'h7fff);
        hold_reqs++;
        run_trajectory(28, 1'b0);
        set_config(16'd3, 16'd1, 16'd16, 16'h0000, 16'hffff);
        run_trajectory(28, 1'b1);
        set_config(16'd127, 16'd1, 16'd2, $urandom, $urandom);
        run_trajectory(26, 1'b0);
        set_config(16'd64, 16'd0, 16'd31, 16'h7fff, 16'h8000);
        run_trajectory(26, 1'b0);
        set_config(16'd2, 16'd1, 16'd5, $urandom, $urandom);
        run_trajectory(24, 1'b0);
        for (int ph = 0; ph < 3; ph++) begin
            set_config($urandom_range(1, 20), $urandom_range(0, 1), $urandom_range(1, 16),
                       $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200);
            if (ph == 1)
                hold_reqs++;
            run_trajectory(30, ph == 2);
        end
        set_config(16'd10, 16'd0, 16'd1, 16'd0, 16'd0);
        run_trajectory(20, 1'b0);

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("covered %0d requests and %0d results over linear and quadratic fits,",
                 requests_sent, results_seen);
        $display("held fits, restarts, saturating offsets and long output back-pressure");
        if (mismatches == 0 && pending_predictions.size() == 0) begin
            $display("[sliding_window_poly_fit_predictor_top] OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_predictions.size());
            $display("[sliding_window_poly_fit_predictor_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/swpf_pkg.sv
hw/rtl/swpf_div.sv
hw/rtl/swpf_lane.sv
hw/rtl/sliding_window_poly_fit_predictor_top.sv
verif/tb_sliding_window_poly_fit_predictor_top.sv
